// ===== rtl/core/lbc_pkg.sv =====
package lbc_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned OPAC_W = 9;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned NUM_LANES = 4;

  localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'd255;
  localparam logic [OPAC_W-1:0] FULL_OPACITY = 9'd256;

  localparam logic [MODE_W-1:0] MODE_NORMAL   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MULTIPLY = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SCREEN   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OVERLAY  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ADD      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SUBTRACT = 3'd5;
  localparam logic [MODE_W-1:0] MODE_LAST     = MODE_SUBTRACT;

  localparam logic CFG_BLEND_MODE = 1'b0;
  localparam logic CFG_OPACITY    = 1'b1;

  typedef logic [CHAN_W-1:0] chan_t;

  // Stage load enables shared by all lanes.
  typedef struct packed {
    logic ld0;
    logic ld1;
  } lane_ctrl_t;

  typedef struct packed {
    chan_t mix;
    chan_t src;
    chan_t dst;
  } lane_result_t;

  typedef struct packed {
    logic load;
    logic op_zero;
    logic pass_src;
  } merge_ctrl_t;

endpackage

// ===== rtl/core/lbc_lane.sv =====
module lbc_lane (
  input  logic                        clk,
  input  lbc_pkg::lane_ctrl_t         ctrl,
  input  logic [lbc_pkg::MODE_W-1:0]  mode,
  input  logic [lbc_pkg::OPAC_W-1:0]  op,
  input  lbc_pkg::chan_t              src,
  input  lbc_pkg::chan_t              dst,
  output lbc_pkg::lane_result_t       result
);

  // Stage 0: operand select and 8x8 product
  lbc_pkg::chan_t  opa;
  lbc_pkg::chan_t  opb;
  logic            dbl;
  logic            comp;

  logic [15:0]     prod_r;
  logic            dbl_r;
  logic            comp_r;
  lbc_pkg::chan_t  s0_r;
  lbc_pkg::chan_t  d0_r;

  always_comb begin
    opa  = src;
    opb  = dst;
    dbl  = 1'b0;
    comp = 1'b0;
    case (mode)
      lbc_pkg::MODE_SCREEN: begin
        opa  = ~src;
        opb  = ~dst;
        comp = 1'b1;
      end
      lbc_pkg::MODE_OVERLAY: begin
        dbl = 1'b1;
        if (dst[7]) begin
          opa  = ~src;
          opb  = ~dst;
          comp = 1'b1;
        end
      end
      default: begin
        opa = src;
        opb = dst;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld0) begin
      prod_r <= opa * opb;
      dbl_r  <= dbl;
      comp_r <= comp;
      s0_r   <= src;
      d0_r   <= dst;
    end
  end

  // Stage 1: divide by 255 and pick the mode result
  logic [16:0]     x;
  logic [8:0]      q0;
  logic [9:0]      r0;
  logic [8:0]      q;
  lbc_pkg::chan_t  m_div;
  logic [8:0]      sum;
  lbc_pkg::chan_t  m_add;
  lbc_pkg::chan_t  m_sub;
  lbc_pkg::chan_t  m_nxt;

  lbc_pkg::chan_t  m1_r;
  lbc_pkg::chan_t  s1_r;
  lbc_pkg::chan_t  d1_r;

  always_comb begin
    x  = dbl_r ? {prod_r, 1'b0} : {1'b0, prod_r};
    // x/256 undershoots x/255; the remainder stays below three times 255
    q0 = x[16:8];
    r0 = {2'b00, x[7:0]} + {1'b0, q0};
    q  = q0 + {8'd0, (r0 >= 10'd255)} + {8'd0, (r0 >= 10'd510)};
    m_div = comp_r ? ~q[7:0] : q[7:0];
    sum   = {1'b0, s0_r} + {1'b0, d0_r};
    m_add = sum[8] ? lbc_pkg::CHAN_MAX : sum[7:0];
    m_sub = (s0_r > d0_r) ? (s0_r - d0_r) : '0;
    case (mode) inside
      lbc_pkg::MODE_NORMAL:                                           m_nxt = s0_r;
      lbc_pkg::MODE_MULTIPLY, lbc_pkg::MODE_SCREEN, lbc_pkg::MODE_OVERLAY: m_nxt = m_div;
      lbc_pkg::MODE_ADD:                                              m_nxt = m_add;
      default:                                                        m_nxt = m_sub;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      m1_r <= m_nxt;
      s1_r <= s0_r;
      d1_r <= d0_r;
    end
  end

  // Opacity mix: d*256 + (m - d)*op, one signed multiply
  logic signed [8:0]  diff;
  logic signed [9:0]  op_s;
  logic signed [18:0] mprod;
  logic signed [19:0] acc;

  always_comb begin
    diff  = $signed({1'b0, m1_r}) - $signed({1'b0, d1_r});
    op_s  = $signed({1'b0, op});
    mprod = diff * op_s;
    acc   = $signed({4'b0000, d1_r, 8'h00}) + $signed({mprod[18], mprod});
  end

  assign result.mix = acc[15:8];
  assign result.src = s1_r;
  assign result.dst = d1_r;

endmodule

// ===== rtl/core/lbc_merge.sv =====
module lbc_merge (
  input  logic                  clk,
  input  lbc_pkg::merge_ctrl_t  ctrl,
  input  lbc_pkg::lane_result_t lane_res [lbc_pkg::NUM_LANES],
  output lbc_pkg::chan_t        pix_r [lbc_pkg::NUM_LANES]
);

  lbc_pkg::chan_t pix_nxt [lbc_pkg::NUM_LANES];

  always_comb begin
    for (int i = 0; i < lbc_pkg::NUM_LANES; i++) begin
      if (ctrl.op_zero) begin
        pix_nxt[i] = lane_res[i].dst;
      end else if (ctrl.pass_src) begin
        pix_nxt[i] = lane_res[i].src;
      end else begin
        pix_nxt[i] = lane_res[i].mix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pix_r <= pix_nxt;
    end
  end

endmodule

// ===== rtl/core/layer_blend_compositor_top.sv =====
// Layer blend compositor: one RGBA8 source pixel over one destination pixel.
// An accepted request passes through the two lane stages and the output
// register before its result is valid. Throughput: one pixel per cycle while
// out_stall is low, set by the four channel lanes each holding one multiply per stage.
// Reset (rst_n low, synchronous) empties the pipeline and sets blend mode to
// normal and opacity to 256.
module layer_blend_compositor_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_index,
  input  logic [lbc_pkg::OPAC_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_src_red,
  input  logic [7:0]                  in_src_green,
  input  logic [7:0]                  in_src_blue,
  input  logic [7:0]                  in_src_alpha,
  input  logic [7:0]                  in_dst_red,
  input  logic [7:0]                  in_dst_green,
  input  logic [7:0]                  in_dst_blue,
  input  logic [7:0]                  in_dst_alpha,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_red,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_blue,
  output logic [7:0]                  out_alpha
);

  logic [lbc_pkg::MODE_W-1:0] mode_r;
  logic [lbc_pkg::OPAC_W-1:0] opac_r;
  logic [lbc_pkg::OPAC_W-1:0] op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= lbc_pkg::MODE_NORMAL;
      opac_r <= lbc_pkg::FULL_OPACITY;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lbc_pkg::CFG_BLEND_MODE: mode_r <= cfg_wdata[lbc_pkg::MODE_W-1:0];
        lbc_pkg::CFG_OPACITY:    opac_r <= cfg_wdata;
        default:                 mode_r <= mode_r;
      endcase
    end
  end

  assign op = (opac_r > lbc_pkg::FULL_OPACITY) ? lbc_pkg::FULL_OPACITY : opac_r;

  // Pipeline occupancy; a stage advances when the next one is empty or moving
  logic v0_r, v1_r, ov_r;
  logic v0_nxt, v1_nxt, ov_nxt;
  logic out_free, adv0, adv1, s0_free, s1_free, in_acc;

  always_comb begin
    out_free = !ov_r || !out_stall;
    adv1     = v1_r && out_free;
    s1_free  = !v1_r || adv1;
    adv0     = v0_r && s1_free;
    s0_free  = !v0_r || adv0;
    in_acc   = in_valid && s0_free;
    v0_nxt   = in_acc ? 1'b1 : (adv0 ? 1'b0 : v0_r);
    v1_nxt   = adv0 ? 1'b1 : (adv1 ? 1'b0 : v1_r);
    ov_nxt   = adv1 ? 1'b1 : ((ov_r && !out_stall) ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign in_stall  = !s0_free;
  assign out_valid = ov_r;

  lbc_pkg::lane_ctrl_t   lane_ctrl;
  lbc_pkg::merge_ctrl_t  merge_ctrl;
  lbc_pkg::lane_result_t lane_res [lbc_pkg::NUM_LANES];
  lbc_pkg::chan_t        lane_src [lbc_pkg::NUM_LANES];
  lbc_pkg::chan_t        lane_dst [lbc_pkg::NUM_LANES];
  lbc_pkg::chan_t        pix      [lbc_pkg::NUM_LANES];

  assign lane_ctrl.ld0 = in_acc;
  assign lane_ctrl.ld1 = adv0;

  assign merge_ctrl.load     = adv1;
  assign merge_ctrl.op_zero  = (op == '0);
  assign merge_ctrl.pass_src = (mode_r > lbc_pkg::MODE_LAST);

  assign lane_src[0] = in_src_red;
  assign lane_src[1] = in_src_green;
  assign lane_src[2] = in_src_blue;
  assign lane_src[3] = in_src_alpha;
  assign lane_dst[0] = in_dst_red;
  assign lane_dst[1] = in_dst_green;
  assign lane_dst[2] = in_dst_blue;
  assign lane_dst[3] = in_dst_alpha;

  for (genvar g = 0; g < lbc_pkg::NUM_LANES - 1; g++) begin : g_color
    lbc_lane u_lane (
      .clk    (clk),
      .ctrl   (lane_ctrl),
      .mode   (mode_r),
      .op     (op),
      .src    (lane_src[g]),
      .dst    (lane_dst[g]),
      .result (lane_res[g])
    );
  end

  // Alpha always takes the source alpha before the mix
  lbc_lane u_lane_alpha (
    .clk    (clk),
    .ctrl   (lane_ctrl),
    .mode   (lbc_pkg::MODE_NORMAL),
    .op     (op),
    .src    (lane_src[lbc_pkg::NUM_LANES-1]),
    .dst    (lane_dst[lbc_pkg::NUM_LANES-1]),
    .result (lane_res[lbc_pkg::NUM_LANES-1])
  );

  lbc_merge u_merge (
    .clk      (clk),
    .ctrl     (merge_ctrl),
    .lane_res (lane_res),
    .pix_r    (pix)
  );

  assign out_red   = pix[0];
  assign out_green = pix[1];
  assign out_blue  = pix[2];
  assign out_alpha = pix[3];

endmodule
